@@ design/pdcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdcc_pkg
// Shared constants, types and helpers for the packet deframer and checksum
// check: byte classes passed from the parser front to the execution back.
// ----------------------------------------------------------------------------
package pdcc_pkg;

    localparam int HEADER_BYTES  = 8;
    localparam int PAYLOAD_BYTES = 512;
    localparam int CHECKED_WORDS = 32;
    localparam int POS_W         = 10;
    localparam int LAST_POS      = HEADER_BYTES + PAYLOAD_BYTES - 1;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_CSUM_HI,
        OP_CSUM_LO,
        OP_LEN_HI,
        OP_LEN_LO,
        OP_SEQ_B3,
        OP_SEQ_B2,
        OP_SEQ_B1,
        OP_SEQ_B0,
        OP_PAY_LO,
        OP_PAY_HI_SUM,
        OP_PAY_HI
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       last;
        logic [7:0] data;
    } t_item;

    // 16-bit add with end-around carry
    function automatic logic [15:0] add_carry(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

@@ design/packet_deframer_checksum_check.sv @@
// ----------------------------------------------------------------------------
// packet_deframer_checksum_check
// Parses fixed-size packets byte by byte: big-endian checksum, length and
// sequence header, payload pass-through and an end-around-carry sum check.
//
//   channel   direction  handshake     beat
//   input     in         push / full   i_rx_byte, i_first_byte
//   result    out        pop / empty   payload, done, checksum_ok, header fields
//
// One result per input beat; one beat per cycle sustained while results are
// popped. The result passes the queue, then the output register, to the ports.
// A four-beat queue parts the position counter from the sum unit; full rises
// only when the result side has stalled long enough to fill it.
// Synchronous reset clears position, sum and header fields, empties the queue
// and clears the output valid flag; the output data register is not reset.
// ----------------------------------------------------------------------------
module packet_deframer_checksum_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_first_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_packet_done,
    output logic        o_checksum_ok,
    output logic [15:0] o_packet_length,
    output logic [31:0] o_sequence_number
);
    import pdcc_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  accept;
    logic  queue_valid;
    logic  back_take;

    assign accept = push && !full;

    pdcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_first_byte(i_first_byte),
        .o_item      (front_item)
    );

    pdcc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_item (front_item),
        .o_full    (full),
        .i_rd_en   (back_take),
        .o_rd_valid(queue_valid),
        .o_rd_item (queue_item)
    );

    pdcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (queue_valid),
        .i_item           (queue_item),
        .o_take           (back_take),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_packet_done    (o_packet_done),
        .o_checksum_ok    (o_checksum_ok),
        .o_packet_length  (o_packet_length),
        .o_sequence_number(o_sequence_number)
    );

endmodule

@@ design/pdcc_front.sv @@
// ----------------------------------------------------------------------------
// pdcc_front
// Tracks the byte position within the packet and tags each incoming beat with
// its class (header field byte, payload low or high byte) and a last flag.
// ----------------------------------------------------------------------------
module pdcc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_first_byte,
    output pdcc_pkg::t_item o_item
);
    import pdcc_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] q;
    logic             last;
    t_op              op;

    always_comb begin
        pos  = i_first_byte ? '0 : r_pos;
        q    = pos - POS_W'(HEADER_BYTES);
        last = (pos >= POS_W'(LAST_POS));
        case (pos)
            POS_W'(0): op = OP_CSUM_HI;
            POS_W'(1): op = OP_CSUM_LO;
            POS_W'(2): op = OP_LEN_HI;
            POS_W'(3): op = OP_LEN_LO;
            POS_W'(4): op = OP_SEQ_B3;
            POS_W'(5): op = OP_SEQ_B2;
            POS_W'(6): op = OP_SEQ_B1;
            POS_W'(7): op = OP_SEQ_B0;
            default: begin
                if (!q[0]) begin
                    op = OP_PAY_LO;
                end else if ({1'b0, q[POS_W-1:1]} < POS_W'(CHECKED_WORDS)) begin
                    op = OP_PAY_HI_SUM;
                end else begin
                    op = OP_PAY_HI;
                end
            end
        endcase
        n_pos = last ? '0 : pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    assign o_item = '{op: op, last: last, data: i_rx_byte};

endmodule

@@ design/pdcc_queue.sv @@
// ----------------------------------------------------------------------------
// pdcc_queue
// Short first-in first-out queue of classified beats between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module pdcc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  pdcc_pkg::t_item i_wr_item,
    output logic            o_full,
    input  logic            i_rd_en,
    output logic            o_rd_valid,
    output pdcc_pkg::t_item o_rd_item
);
    import pdcc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr;
    logic              rd;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign wr         = i_wr_en && !o_full;
    assign rd         = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/pdcc_back.sv @@
// ----------------------------------------------------------------------------
// pdcc_back
// Carries out classified beats: captures header fields, keeps the running
// end-around-carry sum and holds one result in an output register.
// ----------------------------------------------------------------------------
module pdcc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pdcc_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic            o_payload_valid,
    output logic [7:0]      o_payload_byte,
    output logic            o_packet_done,
    output logic            o_checksum_ok,
    output logic [15:0]     o_packet_length,
    output logic [31:0]     o_sequence_number
);
    import pdcc_pkg::*;

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_csum, n_csum;
    logic [15:0] r_len, n_len;
    logic [31:0] r_seq, n_seq;
    logic [7:0]  r_held, n_held;
    logic        n_pv;

    logic        r_out_valid;
    logic        r_out_pv;
    logic [7:0]  r_out_byte;
    logic        r_out_done;
    logic        r_out_ok;
    logic [15:0] r_out_len;
    logic [31:0] r_out_seq;

    logic [7:0]  b;

    assign o_take = i_valid && (!r_out_valid || i_pop);
    assign b      = i_item.data;

    always_comb begin
        n_sum  = r_sum;
        n_csum = r_csum;
        n_len  = r_len;
        n_seq  = r_seq;
        n_held = r_held;
        n_pv   = 1'b0;
        case (i_item.op)
            OP_CSUM_HI: begin
                n_csum = {b, 8'd0};
                n_sum  = '0;
            end
            OP_CSUM_LO: n_csum = {r_csum[15:8], b};
            OP_LEN_HI:  n_len  = {b, 8'd0};
            OP_LEN_LO: begin
                n_len = {r_len[15:8], b};
                n_sum = add_carry(r_sum, {r_len[15:8], b});
            end
            OP_SEQ_B3:  n_seq  = {b, 24'd0};
            OP_SEQ_B2: begin
                n_seq = {r_seq[31:24], b, 16'd0};
                n_sum = add_carry(r_sum, {r_seq[31:24], b});
            end
            OP_SEQ_B1:  n_seq  = {r_seq[31:16], b, 8'd0};
            OP_SEQ_B0: begin
                n_seq = {r_seq[31:8], b};
                n_sum = add_carry(r_sum, {r_seq[15:8], b});
            end
            OP_PAY_LO: begin
                n_held = b;
                n_pv   = 1'b1;
            end
            OP_PAY_HI_SUM: begin
                n_sum = add_carry(r_sum, {b, r_held});
                n_pv  = 1'b1;
            end
            OP_PAY_HI:  n_pv   = 1'b1;
            default:    n_pv   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_csum      <= '0;
            r_len       <= '0;
            r_seq       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_sum       <= n_sum;
                r_csum      <= n_csum;
                r_len       <= n_len;
                r_seq       <= n_seq;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_pv   <= n_pv;
            r_out_byte <= n_pv ? b : 8'd0;
            r_out_done <= i_item.last;
            r_out_ok   <= i_item.last && (n_sum == n_csum);
            r_out_len  <= i_item.last ? n_len : 16'd0;
            r_out_seq  <= i_item.last ? n_seq : 32'd0;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_payload_valid   = r_out_pv;
    assign o_payload_byte    = r_out_byte;
    assign o_packet_done     = r_out_done;
    assign o_checksum_ok     = r_out_ok;
    assign o_packet_length   = r_out_len;
    assign o_sequence_number = r_out_seq;

`ifndef NO_ASSERTIONS
    // the last beat of a packet always lies in the payload
    a_done_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_pv)
        else $error("packet end outside payload");

    // header fields report zero away from the packet end
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_done |-> !r_out_ok && r_out_len == '0 && r_out_seq == '0)
        else $error("header fields reported before packet end");

    // a first header byte restarts the running sum
    a_sum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_item.op == OP_CSUM_HI |=> r_sum == '0)
        else $error("sum not cleared at packet start");
`endif

endmodule

@@ dv/packet_deframer_checksum_check_tb.sv @@
// ----------------------------------------------------------------------------
// packet_deframer_checksum_check_tb
// Streams received packet bytes into the deframer and checks every result
// beat against a cycle-free model of the parser and the end-around-carry sum.
// A short directed run covers header extremes and resync on first_byte. Broken
// fragments and one full frame follow, the frame spread over four phases of
// differing input idling and result stalls, then the head of a further frame
// without a first-byte flag, relying on the position wrap. The result side is
// held off once, long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module packet_deframer_checksum_check_tb;
    import pdcc_pkg::*;

    localparam int FRAME_BYTES    = HEADER_BYTES + PAYLOAD_BYTES;
    localparam int FRAME_PART     = FRAME_BYTES / 4;
    localparam int WRAP_BYTES     = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic        pv;
        logic [7:0]  pb;
        logic        done;
        logic        ok;
        logic [15:0] len;
        logic [31:0] seq;
    } t_pkt_result;

    class checksum_scoreboard;
        logic [POS_W-1:0] pos;
        logic [15:0]      sum;
        logic [15:0]      rx_csum;
        logic [15:0]      len_hdr;
        logic [31:0]      seq_hdr;
        logic [7:0]       low_byte;
        t_pkt_result      expected_q[$];
        int               mismatches;

        function new();
            pos        = '0;
            sum        = '0;
            rx_csum    = '0;
            len_hdr    = '0;
            seq_hdr    = '0;
            low_byte   = '0;
            mismatches = 0;
        endfunction

        static function logic [15:0] end_around_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_rx_byte(logic [7:0] b, logic first);
            t_pkt_result r;
            int unsigned p;
            int unsigned q;
            t_op         op;
            r = '0;
            if (first) begin
                pos = '0;
                sum = '0;
            end
            p = pos;
            if (p == 0) sum = '0;
            q = p - HEADER_BYTES;
            if (p < HEADER_BYTES) op = t_op'(p);
            else if (q[0] == 1'b0) op = OP_PAY_LO;
            else if ((q >> 1) < CHECKED_WORDS) op = OP_PAY_HI_SUM;
            else op = OP_PAY_HI;
            case (op)
                OP_CSUM_HI: rx_csum = {b, 8'h00};
                OP_CSUM_LO: rx_csum[7:0] = b;
                OP_LEN_HI:  len_hdr = {b, 8'h00};
                OP_LEN_LO: begin
                    len_hdr[7:0] = b;
                    sum = end_around_add(sum, len_hdr);
                end
                OP_SEQ_B3:  seq_hdr = {b, 24'h0};
                OP_SEQ_B2: begin
                    seq_hdr = {seq_hdr[31:24], b, 16'h0};
                    sum = end_around_add(sum, seq_hdr[31:16]);
                end
                OP_SEQ_B1:  seq_hdr = {seq_hdr[31:16], b, 8'h00};
                OP_SEQ_B0: begin
                    seq_hdr[7:0] = b;
                    sum = end_around_add(sum, seq_hdr[15:0]);
                end
                OP_PAY_LO: begin
                    low_byte = b;
                end
                OP_PAY_HI_SUM: begin
                    sum = end_around_add(sum, {b, low_byte});
                end
                default: ;
            endcase
            if (p >= HEADER_BYTES) begin
                r.pv = 1'b1;
                r.pb = b;
            end
            if (p >= LAST_POS) begin
                r.done = 1'b1;
                r.ok   = (sum == rx_csum);
                r.len  = len_hdr;
                r.seq  = seq_hdr;
                pos    = '0;
            end else begin
                pos = POS_W'(p + 1);
            end
            expected_q.push_back(r);
        endfunction

        function void check_output(t_pkt_result got);
            t_pkt_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: %s",
                             $time, $sformatf("pv=%0d pb=%02h done=%0d ok=%0d len=%04h seq=%08h",
                             got.pv, got.pb, got.done, got.ok, got.len, got.seq));
                return;
            end
            want = expected_q.pop_front();
            if (got.pv !== want.pv || got.pb !== want.pb || got.done !== want.done ||
                got.ok !== want.ok || got.len !== want.len || got.seq !== want.seq) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp pv=%0d pb=%02h done=%0d ok=%0d len=%04h seq=%08h",
                             $time, want.pv, want.pb, want.done, want.ok, want.len, want.seq);
                    $display("%0t:          got pv=%0d pb=%02h done=%0d ok=%0d len=%04h seq=%08h",
                             $time, got.pv, got.pb, got.done, got.ok, got.len, got.seq);
                end
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  rx_byte      = 8'h00;
    logic        first_byte   = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_done;
    logic        checksum_ok;
    logic [15:0] packet_length;
    logic [31:0] sequence_number;

    checksum_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    logic [7:0] frame_bytes [0:FRAME_BYTES-1];

    // first_byte flag in bit 8
    logic [8:0] directed_beats [0:23] = '{
        9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
        9'h000, 9'h0FF, 9'h0FF, 9'h000,
        9'h100, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h0AA, 9'h055,
        9'h180, 9'h07F
    };

    packet_deframer_checksum_check u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (rx_byte),
        .i_first_byte      (first_byte),
        .empty             (empty),
        .pop               (pop),
        .o_payload_valid   (payload_valid),
        .o_payload_byte    (payload_byte),
        .o_packet_done     (packet_done),
        .o_checksum_ok     (checksum_ok),
        .o_packet_length   (packet_length),
        .o_sequence_number (sequence_number)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side
    initial begin
        t_pkt_result got_beat;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got_beat = {payload_valid, payload_byte, packet_done, checksum_ok,
                            packet_length, sequence_number};
                sb.check_output(got_beat);
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    task automatic send_beat(logic [7:0] b, logic f);
        push       <= 1'b1;
        rx_byte    <= b;
        first_byte <= f;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_rx_byte(b, f);
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_frame(bit good);
        logic [15:0] len;
        logic [15:0] csum;
        logic [15:0] s;
        logic [31:0] seq;
        int unsigned fill;
        case ($urandom_range(3))
            0:       len = 16'(FRAME_BYTES);
            1:       len = 16'hFFFF;
            2:       len = 16'h0000;
            default: len = 16'($urandom_range(16'hFFFF));
        endcase
        seq = $urandom;
        if ($urandom_range(3) == 0) seq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        fill = $urandom_range(7);
        for (int i = HEADER_BYTES; i < FRAME_BYTES; i++)
            frame_bytes[i] = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom_range(255));
        s = checksum_scoreboard::end_around_add(16'h0000, len);
        s = checksum_scoreboard::end_around_add(s, seq[31:16]);
        s = checksum_scoreboard::end_around_add(s, seq[15:0]);
        for (int w = 0; w < CHECKED_WORDS && 2 * w + 1 < PAYLOAD_BYTES; w++)
            s = checksum_scoreboard::end_around_add(
                    s, {frame_bytes[HEADER_BYTES + 2 * w + 1],
                        frame_bytes[HEADER_BYTES + 2 * w]});
        csum = good ? s : s ^ (16'h0001 << $urandom_range(15));
        frame_bytes[0] = csum[15:8];
        frame_bytes[1] = csum[7:0];
        frame_bytes[2] = len[15:8];
        frame_bytes[3] = len[7:0];
        frame_bytes[4] = seq[31:24];
        frame_bytes[5] = seq[23:16];
        frame_bytes[6] = seq[15:8];
        frame_bytes[7] = seq[7:0];
    endtask

    // bytes from_idx up to to_idx - 1 of the built frame
    task automatic send_frame(int from_idx, int to_idx, bit lead_flag);
        for (int i = from_idx; i < to_idx; i++) begin
            idle_gap();
            send_beat(frame_bytes[i], lead_flag && i == 0);
        end
    endtask

    // broken sequence: restart then random bytes, stray restarts inside
    task automatic send_fragment();
        int unsigned n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            idle_gap();
            send_beat(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++)
            send_beat(directed_beats[i][7:0], directed_beats[i][8]);
        drain();

        build_frame($urandom_range(3) != 0);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; pop_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  pop_stall_pct = 51; end
                default: begin send_idle_pct = 32; pop_stall_pct = 32; end
            endcase
            if (phase == 0) begin
                send_fragment();
                send_fragment();
                // hold the result side so the input stalls on full
                hold_left = LONG_HOLD;
            end
            send_frame(phase * FRAME_PART, (phase + 1) * FRAME_PART, 1'b1);
        end
        // next frame head straight after, relying on the position wrap
        build_frame(1'b1);
        send_frame(0, WRAP_BYTES, 1'b0);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/pdcc_pkg.sv
design/pdcc_front.sv
design/pdcc_queue.sv
design/pdcc_back.sv
design/packet_deframer_checksum_check.sv
dv/packet_deframer_checksum_check_tb.sv
